>>> rtl/encoder_position_speed_estimator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder position and speed estimator
// Shared shorthand for clocked, reset-qualified concurrent checks
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_SPEED_ESTIMATOR_UNIT_DEFINES_SVH
`define ENCODER_POSITION_SPEED_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define EPS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eps check failed");

// next-cycle implication, checked while out of reset
`define EPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eps check failed");

`endif

>>> rtl/eps_pkg.sv
// ----------------------------------------------------------------------------
// eps_pkg
// Types, widths and constants of the encoder position and speed estimator
// ----------------------------------------------------------------------------
`default_nettype none

package eps_pkg;

  // operation codes carried in the input tuser
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRAP_DN = 2'd1;
  localparam logic [OP_W-1:0] OP_WRAP_UP = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_CPR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b1;

  // field widths
  localparam int CNT_W       = 16;
  localparam int POS_W       = 13;
  localparam int SPD_W       = 16;
  localparam int CPR_W       = 15;
  localparam int PER_W       = 10;
  localparam int OUT_TDATA_W = 32;

  // reset values of the configuration registers
  localparam logic [CPR_W-1:0] CPR_RESET = 15'd4096;
  localparam logic [PER_W-1:0] PER_RESET = 10'd1;

  // scale factors
  localparam int SCALE_W = 12;
  localparam logic [SCALE_W-1:0] POS_SCALE = 12'd3600;
  localparam logic [SCALE_W-1:0] RAW_SCALE = 12'd1000;

  // serial divider sizing: magnitude times scale fits 27 bits
  localparam int DVD_W     = 27;
  localparam int DVS_W     = 16;
  localparam int QUO_W     = 16;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // moving average ring, depth must be a power of two
  localparam int AVG_DEPTH = 8;
  localparam int AVG_LOG2  = $clog2(AVG_DEPTH);
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? AVG_LOG2 : 1;
  localparam int SUM_W     = CNT_W + SLOT_W;

  // divider request and status
  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/eps_divider.sv
// ----------------------------------------------------------------------------
// eps_divider
// Bit-serial restoring divider, one quotient bit per cycle, signed result
// ----------------------------------------------------------------------------
`default_nettype none

module eps_divider (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire eps_pkg::div_req_t         req,
  input  wire logic [eps_pkg::DVD_W-1:0] dividend,
  input  wire logic [eps_pkg::DVS_W-1:0] divisor,
  output eps_pkg::div_stat_t             stat,
  output logic [eps_pkg::QUO_W-1:0]      quotient
);
  import eps_pkg::*;

  logic [DVS_W-1:0]     rem_r;
  logic [DVD_W-1:0]     dq_r;
  logic [DVS_W-1:0]     dvs_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DVS_W+1:0]     trial;
  logic                 qbit;
  logic [DVS_W:0]       shifted;

  // one trial subtraction on the remainder with the next dividend bit
  assign shifted = {rem_r, dq_r[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign qbit    = ~trial[DVS_W+1];

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= DIV_CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= (divisor == '0) ? DVS_W'(1) : divisor;
      neg_r <= req.neg;
    end else if (cnt_r != '0) begin
      rem_r <= qbit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      dq_r  <= {dq_r[DVD_W-2:0], qbit};
    end
  end

  // low quotient bits with the sign applied
  assign quotient  = neg_r ? (QUO_W'(0) - dq_r[QUO_W-1:0]) : dq_r[QUO_W-1:0];
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

`default_nettype wire

>>> rtl/eps_avg.sv
// ----------------------------------------------------------------------------
// eps_avg
// Ring of raw speeds with a running sum, average truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module eps_avg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [eps_pkg::CNT_W-1:0]  raw,
  output logic [eps_pkg::CNT_W-1:0]       avg
);
  import eps_pkg::*;

  logic [CNT_W-1:0]        ring_r [AVG_DEPTH];
  logic [SLOT_W-1:0]       slot_r;
  logic [SLOT_W-1:0]       slot_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] old_x;
  logic signed [SUM_W-1:0] raw_x;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] quot;

  // slot advances before the write and wraps at the end of the ring
  assign slot_nxt = (slot_r >= SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // running sum drops the overwritten entry and adds the new one
  assign old_x   = SUM_W'($signed(ring_r[slot_nxt]));
  assign raw_x   = SUM_W'($signed(raw));
  assign sum_nxt = sum_r - old_x + raw_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      sum_r  <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else if (wr_en) begin
      slot_r           <= slot_nxt;
      sum_r            <= sum_nxt;
      ring_r[slot_nxt] <= raw;
    end
  end

  // divide by the depth, rounding toward zero
  assign biased = sum_r + (sum_r[SUM_W-1] ? SUM_W'(AVG_DEPTH - 1) : SUM_W'(0));
  assign quot   = biased >>> AVG_LOG2;
  assign avg    = quot[CNT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/encoder_position_speed_estimator_unit.sv
// ----------------------------------------------------------------------------
// encoder_position_speed_estimator_unit
// Wrapped encoder position and moving-average speed in tenths
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tdata counter_value, tuser operation
// out_     out  out_tvalid/out_tready tdata position, speed; tuser changed
// cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// a sample item runs three divides (start, 27 quotient steps, done) on one shared
// bit-serial divider, then a hand-off to the output register before it returns to
// idle; wrap items and unused codes are done at transfer and keep the input ready
// synchronous active-low reset clears the control and estimator state, no clearing pass
// a finished result waits in the output register; the next item is taken
// meanwhile, and a later result stalls only if that register is still full
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_position_speed_estimator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [eps_pkg::CNT_W-1:0]      in_tdata,  // [15:0] counter_value
  input  wire logic [eps_pkg::OP_W-1:0]       in_tuser,  // [1:0] operation
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [12:0] position_tenths, [28:13] speed_tenths, [31:29] zero
  output logic [eps_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser, // [0] changed
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [eps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [eps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import eps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_POS_W = 3'd2;
  localparam logic [2:0] S_RAW   = 3'd3;
  localparam logic [2:0] S_RAW_W = 3'd4;
  localparam logic [2:0] S_SPD   = 3'd5;
  localparam logic [2:0] S_SPD_W = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]              state_r;
  logic [CPR_W-1:0]        cpr_r;
  logic [PER_W-1:0]        per_r;
  logic [CPR_W-1:0]        eff_cpr;
  logic [PER_W-1:0]        eff_per;
  logic [CNT_W-1:0]        last_count_r;
  logic [CNT_W-1:0]        last_pos_r;
  logic [SPD_W-1:0]        last_spd_r;
  logic [CNT_W-1:0]        elapsed_r;
  logic signed [CNT_W-1:0] count_r;
  logic signed [CNT_W:0]   diff_r;
  logic [CNT_W-1:0]        pos_r;
  logic [SPD_W-1:0]        spd_r;
  logic                    changed_r;
  logic                    out_valid_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [SPD_W-1:0]        out_spd_r;
  logic                    out_chg_r;

  logic                    in_xfer;
  logic                    out_free;
  logic signed [CNT_W:0]   cv_x;
  logic signed [CNT_W:0]   cpr_x;
  logic signed [CNT_W:0]   wrapped_x;
  logic [CNT_W:0]          el_sum;
  logic [CNT_W-1:0]        el_sat;
  logic signed [CNT_W:0]   opnd_s;
  logic [CNT_W:0]          opnd_abs;
  logic [SCALE_W-1:0]      scale;
  logic [DVS_W-1:0]        div_dvs;
  logic [SCALE_W+CNT_W-1:0] product;
  div_req_t                div_req;
  div_stat_t               div_stat;
  logic [QUO_W-1:0]        div_quo;
  logic                    avg_wr;
  logic [CNT_W-1:0]        avg_val;

  // a zero register value counts as one
  assign eff_cpr = (cpr_r == '0) ? CPR_W'(1) : cpr_r;
  assign eff_per = (per_r == '0) ? PER_W'(1) : per_r;

  // handshakes
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // single wrap of the incoming count into the open revolution range
  assign cv_x  = {in_tdata[CNT_W-1], in_tdata};
  assign cpr_x = {2'b00, eff_cpr};
  always_comb begin
    if (cv_x >= cpr_x) begin
      wrapped_x = cv_x - cpr_x;
    end else if (cv_x <= -cpr_x) begin
      wrapped_x = cv_x + cpr_x;
    end else begin
      wrapped_x = cv_x;
    end
  end

  // elapsed time grows by one period, saturating
  assign el_sum = {1'b0, elapsed_r} + {{(CNT_W + 1 - PER_W){1'b0}}, eff_per};
  assign el_sat = el_sum[CNT_W] ? {CNT_W{1'b1}} : el_sum[CNT_W-1:0];

  // divider operand selection
  always_comb begin
    unique case (state_r)
      S_RAW: begin
        opnd_s  = diff_r;
        scale   = RAW_SCALE;
        div_dvs = elapsed_r;
      end
      S_SPD: begin
        opnd_s  = {avg_val[CNT_W-1], avg_val};
        scale   = POS_SCALE;
        div_dvs = {1'b0, eff_cpr};
      end
      default: begin
        opnd_s  = {count_r[CNT_W-1], count_r};
        scale   = POS_SCALE;
        div_dvs = {1'b0, eff_cpr};
      end
    endcase
  end

  assign opnd_abs      = opnd_s[CNT_W] ? (CNT_W+1)'(-opnd_s) : opnd_s;
  assign product       = {{SCALE_W{1'b0}}, opnd_abs[CNT_W-1:0]} *
                         {{CNT_W{1'b0}}, scale};
  assign div_req.start = (state_r == S_POS) || (state_r == S_RAW) || (state_r == S_SPD);
  assign div_req.neg   = opnd_s[CNT_W];

  eps_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (product[DVD_W-1:0]),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign avg_wr = (state_r == S_RAW_W) && div_stat.done;

  eps_avg u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (avg_wr),
    .raw   (div_quo),
    .avg   (avg_val)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= CPR_RESET;
      per_r <= PER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CPR:    cpr_r <= cfg_data[CPR_W-1:0];
        CFG_PERIOD: per_r <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_count_r <= '0;
      last_pos_r   <= '0;
      last_spd_r   <= '0;
      elapsed_r    <= CNT_W'(1);
      changed_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_tuser)
              OP_SAMPLE:  state_r <= S_POS;
              OP_WRAP_DN: last_count_r <= last_count_r - {1'b0, eff_cpr};
              OP_WRAP_UP: last_count_r <= last_count_r + {1'b0, eff_cpr};
              default: ;
            endcase
          end
        end
        S_POS:   state_r <= S_POS_W;
        S_POS_W: begin
          if (div_stat.done) begin
            changed_r  <= (div_quo != last_pos_r);
            last_pos_r <= div_quo;
            if (div_quo == last_pos_r) begin
              elapsed_r <= el_sat;
            end
            state_r <= S_RAW;
          end
        end
        S_RAW:   state_r <= S_RAW_W;
        S_RAW_W: begin
          if (div_stat.done) begin
            if (changed_r) begin
              elapsed_r <= {{(CNT_W - PER_W){1'b0}}, eff_per};
            end
            last_count_r <= count_r;
            state_r      <= S_SPD;
          end
        end
        S_SPD:   state_r <= S_SPD_W;
        S_SPD_W: begin
          if (div_stat.done) begin
            if (div_quo != last_spd_r) begin
              changed_r <= 1'b1;
            end
            last_spd_r <= div_quo;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // per-sample working values
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      count_r <= wrapped_x[CNT_W-1:0];
    end
    if ((state_r == S_POS_W) && div_stat.done) begin
      pos_r  <= div_quo;
      diff_r <= {count_r[CNT_W-1], count_r} - {last_count_r[CNT_W-1], last_count_r};
    end
    if ((state_r == S_SPD_W) && div_stat.done) begin
      spd_r <= div_quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_pos_r <= pos_r[POS_W-1:0];
      out_spd_r <= spd_r;
      out_chg_r <= changed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - POS_W - SPD_W){1'b0}}, out_spd_r, out_pos_r};
  assign out_tuser  = out_chg_r;

endmodule

`default_nettype wire

>>> rtl/eps_checker.sv
// ----------------------------------------------------------------------------
// eps_checker
// Port-level checks on the estimator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_position_speed_estimator_unit_defines.svh"

module eps_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tvalid,
  input wire logic                     in_tready,
  input wire logic [eps_pkg::OP_W-1:0] in_tuser,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic                     cfg_valid,
  input wire logic                     cfg_ready
);
  import eps_pkg::*;

  // a pending result is not withdrawn
  `EPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // a sample transfer occupies the engine
  `EPS_ASSERT_NEXT(a_sample_busy, in_tvalid && in_tready && (in_tuser == OP_SAMPLE), !in_tready)

  // wrap and unused codes leave the input ready in the cycle after the transfer
  `EPS_ASSERT_NEXT(a_wrap_ready, in_tvalid && in_tready && (in_tuser != OP_SAMPLE), in_tready)

  // configuration writes are never stalled
  `EPS_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind encoder_position_speed_estimator_unit eps_checker u_eps_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder position and speed estimator
// ----------------------------------------------------------------------------
// Items go in on the in_ stream and results come back on the out_ stream.
// A behavioral predictor tracks the count, elapsed-time and moving-average
// state and computes each expected result that is not typed in. Each result is
// compared with the oldest expected one, field by field. A short table of
// directed items runs first at reset settings. Several register settings
// follow, including the extremes and the zero values. Each of them gets a
// burst of random motion, holds, wraps and unused codes. The sender and the
// receiver are paced with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import eps_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 8;
  localparam int ITEMS_PER_PH  = 32;
  localparam int DIR_ROWS      = 20;
  localparam int DEG_TENTHS    = 3600;
  localparam int MS_PER_S      = 1000;
  localparam int ELAPSED_MAX   = 65535;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one expected result
  typedef struct {
    logic signed [POS_W-1:0] pos;
    logic signed [SPD_W-1:0] spd;
    logic                    chg;
  } enc_result_t;

  // one directed item, with its expected result where typed in
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] val;
    logic             typed;
    logic [POS_W-1:0] pos;
    logic [SPD_W-1:0] spd;
    logic             chg;
  } enc_item_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [CNT_W-1:0]      in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = OP_SAMPLE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_CPR;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // predictor state and settings
  int unsigned cpr_setting    = 32'(CPR_RESET);
  int unsigned period_setting = 32'(PER_RESET);
  int          prev_count;
  int          prev_pos;
  int          prev_spd;
  int          hold_ms;
  int          speed_hist [AVG_DEPTH];
  int          hist_slot;

  enc_result_t pending_results [$];
  int          error_count    = 0;
  int          results_seen   = 0;
  int          items_sent     = 0;
  int          settings_count = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  enc_item_t dir_rows [0:DIR_ROWS-1] = '{
    '{OP_SAMPLE,  16'h0000, 1'b1, 13'd0, 16'd0, 1'b0},  // at rest after reset
    '{OP_UNUSED,  16'hFFFF, 1'b0, 13'd0, 16'd0, 1'b0},  // unused code, dropped
    '{OP_SAMPLE,  16'h0000, 1'b1, 13'd0, 16'd0, 1'b0},  // still at rest
    '{OP_SAMPLE,  16'h7FFF, 1'b0, 13'd0, 16'd0, 1'b0},  // largest count
    '{OP_SAMPLE,  16'h8000, 1'b0, 13'd0, 16'd0, 1'b0},  // smallest count
    '{OP_SAMPLE,  16'h1000, 1'b0, 13'd0, 16'd0, 1'b0},  // exactly one rev
    '{OP_SAMPLE,  16'hF000, 1'b0, 13'd0, 16'd0, 1'b0},  // minus one rev
    '{OP_SAMPLE,  16'h0FFF, 1'b0, 13'd0, 16'd0, 1'b0},  // just under one rev
    '{OP_SAMPLE,  16'hF001, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_WRAP_DN, 16'h0000, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_SAMPLE,  16'h0001, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_WRAP_UP, 16'h0000, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_WRAP_UP, 16'hFFFF, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_SAMPLE,  16'hFFFF, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_SAMPLE,  16'hFFFF, 1'b0, 13'd0, 16'd0, 1'b0},  // position holds
    '{OP_SAMPLE,  16'hFFFF, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_SAMPLE,  16'h5555, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_SAMPLE,  16'hAAAA, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_UNUSED,  16'h0000, 1'b0, 13'd0, 16'd0, 1'b0},
    '{OP_SAMPLE,  16'h0800, 1'b0, 13'd0, 16'd0, 1'b0}
  };

  // settings per phase; phases flagged in phase_rand draw random legal values
  int unsigned phase_cpr    [PHASES] = '{4096, 1, 32767, 0, 360, 0, 2048, 0};
  int unsigned phase_period [PHASES] = '{1, 1000, 32'h7FFF, 0, 7, 0, 1000, 0};
  bit          phase_rand   [PHASES] = '{0, 0, 0, 0, 0, 1, 0, 1};

  encoder_position_speed_estimator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // two's complement wrap to 16 bits
  function automatic int wrap16(input int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic void clear_estimate();
    prev_count = 0;
    prev_pos   = 0;
    prev_spd   = 0;
    hold_ms    = 1;
    hist_slot  = 0;
    foreach (speed_hist[i]) speed_hist[i] = 0;
  endfunction

  // advance the estimate by one item; returns 1 when a result is due
  function automatic bit estimate_step(input logic [OP_W-1:0] op,
                                       input logic [CNT_W-1:0] raw_cnt,
                                       output enc_result_t res);
    int cpr, per, cnt, pos, raw, sum, avg, spd, div;
    bit moved;
    cpr = (cpr_setting == 0) ? 1 : int'(cpr_setting);
    per = (period_setting == 0) ? 1 : int'(period_setting);
    res = '{default: '0};
    if (op == OP_WRAP_DN) begin
      prev_count = wrap16(prev_count - cpr);
      return 1'b0;
    end
    if (op == OP_WRAP_UP) begin
      prev_count = wrap16(prev_count + cpr);
      return 1'b0;
    end
    if (op != OP_SAMPLE) return 1'b0;

    // single wrap into one revolution, then position in tenths
    cnt = int'($signed(raw_cnt));
    if (cnt >= cpr) cnt -= cpr;
    else if (cnt <= -cpr) cnt += cpr;
    pos = wrap16(cnt * DEG_TENTHS / cpr);
    moved = (pos != prev_pos);
    if (!moved) begin
      hold_ms += per;
      if (hold_ms > ELAPSED_MAX) hold_ms = ELAPSED_MAX;
    end
    prev_pos = pos;

    // raw speed over the time since the last change
    div = (hold_ms == 0) ? 1 : hold_ms;
    raw = wrap16((cnt - prev_count) * MS_PER_S / div);
    if (moved) hold_ms = per;
    prev_count = cnt;

    // ring average
    hist_slot = (hist_slot >= AVG_DEPTH - 1) ? 0 : hist_slot + 1;
    speed_hist[hist_slot] = raw;
    sum = 0;
    foreach (speed_hist[i]) sum += speed_hist[i];
    avg = wrap16(sum / AVG_DEPTH);
    spd = wrap16(avg * DEG_TENTHS / cpr);
    if (spd != prev_spd) moved = 1'b1;
    prev_spd = spd;

    res.pos = pos[POS_W-1:0];
    res.spd = spd[SPD_W-1:0];
    res.chg = moved;
    return 1'b1;
  endfunction

  function automatic enc_item_t plain_item(input logic [OP_W-1:0] op,
                                           input logic [CNT_W-1:0] val);
    enc_item_t it;
    it = '0;
    it.op  = op;
    it.val = val;
    return it;
  endfunction

  // one input transfer; tvalid stays high unless a gap is taken
  task automatic push_item(input enc_item_t it);
    enc_result_t res;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= it.val;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (estimate_step(it.op, it.val, res)) begin
      if (it.typed) begin
        res.pos = it.pos;
        res.spd = it.spd;
        res.chg = it.chg;
      end
      pending_results.push_back(res);
    end
  endtask

  // write both registers back to back while the block is idle
  task automatic write_settings(input logic [CFG_DATA_W-1:0] cpr_val,
                                input logic [CFG_DATA_W-1:0] per_val);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CPR;
    cfg_data  <= cpr_val;
    do @(posedge clk); while (!cfg_ready);
    cpr_setting = 32'(cpr_val[CPR_W-1:0]);
    cfg_index <= CFG_PERIOD;
    cfg_data  <= per_val;
    do @(posedge clk); while (!cfg_ready);
    period_setting = 32'(per_val[PER_W-1:0]);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // random motion: small steps, holds, wraps, jumps and unused codes
  task automatic run_random(input int n_items);
    int k, pick, run;
    logic [CNT_W-1:0] enc_cnt;
    enc_cnt = CNT_W'($urandom);
    k = 0;
    while (k < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        run = $urandom_range(80, 2);
        if (run > n_items - k) run = n_items - k;
        repeat (run) push_item(plain_item(OP_SAMPLE, enc_cnt));
        k += run;
      end else if (pick < 57) begin
        enc_cnt = enc_cnt + CNT_W'($urandom_range(40)) - CNT_W'(20);
        push_item(plain_item(OP_SAMPLE, enc_cnt));
        k++;
      end else if (pick < 70) begin
        push_item(plain_item(($urandom_range(1) != 0) ? OP_WRAP_UP : OP_WRAP_DN,
                             CNT_W'($urandom)));
        k++;
      end else if (pick < 75) begin
        push_item(plain_item(OP_UNUSED, CNT_W'($urandom)));
      end else begin
        enc_cnt = CNT_W'($urandom);
        push_item(plain_item(OP_SAMPLE, enc_cnt));
        k++;
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // result check against the oldest expectation, receiver pacing
  always @(posedge clk) begin : rx_check
    enc_result_t want;
    logic signed [POS_W-1:0] got_pos;
    logic signed [SPD_W-1:0] got_spd;
    got_pos = out_tdata[POS_W-1:0];
    got_spd = out_tdata[POS_W+SPD_W-1:POS_W];
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: position %0d speed %0d", got_pos, got_spd);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got_pos !== want.pos) begin
          $error("position_tenths: expected %0d, got %0d", want.pos, got_pos);
          error_count++;
        end
        if (got_spd !== want.spd) begin
          $error("speed_tenths: expected %0d, got %0d", want.spd, got_spd);
          error_count++;
        end
        if (out_tuser !== want.chg) begin
          $error("changed: expected %0b, got %0b", want.chg, out_tuser);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:POS_W+SPD_W] !== '0) begin
          $error("tdata pad: expected 0, got %0h",
                 out_tdata[OUT_TDATA_W-1:POS_W+SPD_W]);
          error_count++;
        end
      end
    end
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // main sequence
  initial begin
    logic [CFG_DATA_W-1:0] cpr_val, per_val;
    clear_estimate();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at reset settings
    for (int i = 0; i < DIR_ROWS; i++) push_item(dir_rows[i]);
    in_tvalid <= 1'b0;

    // phases over settings and pacing
    for (int p = 0; p < PHASES; p++) begin
      cpr_val = phase_rand[p] ? CFG_DATA_W'($urandom_range(32767, 1)) :
                                CFG_DATA_W'(phase_cpr[p]);
      per_val = phase_rand[p] ? CFG_DATA_W'($urandom_range(1000, 1)) :
                                CFG_DATA_W'(phase_period[p]);
      write_settings(cpr_val, per_val);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // long hold so the elapsed time saturates at long periods
      if (period_setting >= 1000)
        repeat (70) push_item(plain_item(OP_SAMPLE, 16'h0123));
      run_random(ITEMS_PER_PH);
    end

    // drain
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d items over %0d register settings with four pacing modes",
             items_sent, settings_count + 1);
    $display("compared %0d results, %0d mismatches", results_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
